FILE: rtl/radial_gray_fade_filter_core_macros.svh
// Assertion macros for the radial gray fade filter RTL
`ifndef RADIAL_GRAY_FADE_FILTER_CORE_MACROS_SVH
`define RADIAL_GRAY_FADE_FILTER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define RGFF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgff assertion failed");

// Check a condition in the cycle after its trigger
`define RGFF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgff assertion failed");

`endif

FILE: rtl/rgff_pkg.sv
// Types and constants for the radial gray fade filter
package rgff_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 4;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int RAD_W      = 16;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = CHAN_W + 2;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int VAL_W      = SQ_W + 2 * FRAC_BITS;
    localparam int SQRT_STEPS = (VAL_W + 1) / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int WORK_W     = 2 * SQRT_STEPS;
    localparam int W3_W       = RAD_W + 2;
    localparam int NUM_W      = W3_W + CHAN_W;
    localparam int DIV_STEPS  = CHAN_W;
    localparam int PROD_W     = SUM_W + 1 + RAD_W + 1;
    localparam int GRAY_MUL_W = 10;
    localparam int GRAY_SHIFT = 11;

    localparam logic [GRAY_MUL_W-1:0] GRAY_MUL     = GRAY_MUL_W'(683);
    localparam logic [RAD_W-1:0]      OUTER_RESET  = RAD_W'(16);

    typedef enum logic [1:0] {
        ZONE_INSIDE = 2'd0,
        ZONE_FADE   = 2'd1,
        ZONE_GRAY   = 2'd2
    } zone_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTER_X     = CFG_ADDR_W'(0),
        CFG_CENTER_Y     = CFG_ADDR_W'(1),
        CFG_INNER_RADIUS = CFG_ADDR_W'(2),
        CFG_OUTER_RADIUS = CFG_ADDR_W'(3)
    } cfg_reg_t;

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] chan_arr_t;
    typedef logic [NUM_CHAN-1:0][NUM_W-1:0]  num_arr_t;

    typedef struct packed {
        chan_arr_t         ch;
        logic [SUM_W-1:0]  sum;
        logic [CHAN_W-1:0] gray;
    } sqrt_tag_t;

    typedef struct packed {
        zone_t             zone;
        chan_arr_t         ch;
        logic [CHAN_W-1:0] gray;
    } div_tag_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

FILE: rtl/rgff_isqrt.sv
// Pipelined integer square root, one result bit per stage
module rgff_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rgff_pkg::pipe_ctl_t           in_ctl,
    input  logic [rgff_pkg::VAL_W-1:0]    in_val,
    input  rgff_pkg::sqrt_tag_t           in_tag,
    output logic                          out_valid,
    output logic [rgff_pkg::ROOT_W-1:0]   out_root,
    output rgff_pkg::sqrt_tag_t           out_tag
);
    localparam int N = rgff_pkg::SQRT_STEPS;
    localparam int W = rgff_pkg::WORK_W;

    logic [N-1:0]        valid_reg;
    logic [W-1:0]        rem_reg  [N];
    logic [W-1:0]        root_reg [N];
    rgff_pkg::sqrt_tag_t tag_reg  [N];

    logic [W-1:0]        rem_src  [N];
    logic [W-1:0]        root_src [N];
    rgff_pkg::sqrt_tag_t tag_src  [N];

    always_comb begin
        rem_src[0]  = W'(in_val);
        root_src[0] = '0;
        tag_src[0]  = in_tag;
        for (int i = 1; i < N; i++) begin
            rem_src[i]  = rem_reg[i-1];
            root_src[i] = root_reg[i-1];
            tag_src[i]  = tag_reg[i-1];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [W-1:0] bit_val;
        logic [W:0]   trial;
        logic [W-1:0] rem_next;
        logic [W-1:0] root_next;

        always_comb begin
            bit_val = W'(1) << (2 * (N - 1 - i));
            trial   = {1'b0, root_src[i]} + {1'b0, bit_val};
            if ({1'b0, rem_src[i]} >= trial) begin
                rem_next  = rem_src[i] - trial[W-1:0];
                root_next = (root_src[i] >> 1) + bit_val;
            end else begin
                rem_next  = rem_src[i];
                root_next = root_src[i] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (in_ctl.advance) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                tag_reg[i]  <= tag_src[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (in_ctl.advance) begin
            valid_reg <= {valid_reg[N-2:0], in_ctl.valid};
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1][rgff_pkg::ROOT_W-1:0];
    assign out_tag   = tag_reg[N-1];

endmodule

FILE: rtl/rgff_div.sv
// Pipelined restoring divider, three lanes sharing one divisor
module rgff_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rgff_pkg::pipe_ctl_t           in_ctl,
    input  rgff_pkg::num_arr_t            in_num,
    input  logic [rgff_pkg::W3_W-1:0]     in_den,
    input  rgff_pkg::div_tag_t            in_tag,
    output logic                          out_valid,
    output rgff_pkg::chan_arr_t           out_quot,
    output rgff_pkg::div_tag_t            out_tag
);
    localparam int N  = rgff_pkg::DIV_STEPS;
    localparam int NW = rgff_pkg::NUM_W;
    localparam int L  = rgff_pkg::NUM_CHAN;

    logic [N-1:0]                valid_reg;
    rgff_pkg::num_arr_t          rem_reg  [N];
    rgff_pkg::chan_arr_t         quot_reg [N];
    logic [rgff_pkg::W3_W-1:0]   den_reg  [N];
    rgff_pkg::div_tag_t          tag_reg  [N];

    rgff_pkg::num_arr_t          rem_src  [N];
    rgff_pkg::chan_arr_t         quot_src [N];
    logic [rgff_pkg::W3_W-1:0]   den_src  [N];
    rgff_pkg::div_tag_t          tag_src  [N];

    always_comb begin
        rem_src[0]  = in_num;
        quot_src[0] = '0;
        den_src[0]  = in_den;
        tag_src[0]  = in_tag;
        for (int i = 1; i < N; i++) begin
            rem_src[i]  = rem_reg[i-1];
            quot_src[i] = quot_reg[i-1];
            den_src[i]  = den_reg[i-1];
            tag_src[i]  = tag_reg[i-1];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [NW-1:0]       den_sh;
        rgff_pkg::num_arr_t  rem_next;
        rgff_pkg::chan_arr_t quot_next;

        always_comb begin
            den_sh    = NW'(den_src[i]) << (N - 1 - i);
            rem_next  = rem_src[i];
            quot_next = quot_src[i];
            for (int k = 0; k < L; k++) begin
                if (rem_src[i][k] >= den_sh) begin
                    rem_next[k]             = rem_src[i][k] - den_sh;
                    quot_next[k][N - 1 - i] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (in_ctl.advance) begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= quot_next;
                den_reg[i]  <= den_src[i];
                tag_reg[i]  <= tag_src[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (in_ctl.advance) begin
            valid_reg <= {valid_reg[N-2:0], in_ctl.valid};
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

FILE: rtl/radial_gray_fade_filter_core.sv
// Radial gray fade filter top level: one pixel per clock while the output is not stalled. Each
// request passes three coordinate stages, a 17-stage square-root pipeline that sets most of
// the latency, three zone and product stages, an 8-stage divider and the output register.
// A stall on the result side freezes the whole pipeline; s_ready is high whenever the output
// register is empty or being taken. Configuration writes take effect at once and are meant
// to be made while no request is in flight.
module radial_gray_fade_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgff_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rgff_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rgff_pkg::COORD_BITS-1:0]    s_pixel_x,
    input  logic [rgff_pkg::COORD_BITS-1:0]    s_pixel_y,
    input  logic [rgff_pkg::CHAN_W-1:0]        s_chan_a,
    input  logic [rgff_pkg::CHAN_W-1:0]        s_chan_b,
    input  logic [rgff_pkg::CHAN_W-1:0]        s_chan_c,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rgff_pkg::CHAN_W-1:0]        m_out_a,
    output logic [rgff_pkg::CHAN_W-1:0]        m_out_b,
    output logic [rgff_pkg::CHAN_W-1:0]        m_out_c,
    output logic [1:0]                         m_zone
);
    localparam int CB = rgff_pkg::COORD_BITS;
    localparam int CW = rgff_pkg::CHAN_W;
    localparam int RW = rgff_pkg::RAD_W;
    localparam int SW = rgff_pkg::SUM_W;
    localparam int L  = rgff_pkg::NUM_CHAN;

    logic [CB-1:0] center_x_reg, center_y_reg;
    logic [RW-1:0] inner_reg, outer_reg;

    logic advance;
    logic m_valid_reg;
    rgff_pkg::pipe_ctl_t sq_ctl, dv_ctl;

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            inner_reg    <= '0;
            outer_reg    <= rgff_pkg::OUTER_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                rgff_pkg::CFG_CENTER_X:     center_x_reg <= cfg_wdata[CB-1:0];
                rgff_pkg::CFG_CENTER_Y:     center_y_reg <= cfg_wdata[CB-1:0];
                rgff_pkg::CFG_INNER_RADIUS: inner_reg    <= cfg_wdata[RW-1:0];
                rgff_pkg::CFG_OUTER_RADIUS: outer_reg    <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: distances, sum, gray level
    logic [CB-1:0] dx_next, dy_next;
    logic [SW-1:0] sum_next;
    logic [SW+rgff_pkg::GRAY_MUL_W-1:0] gray_prod;
    logic [CB-1:0] dx1_reg, dy1_reg;
    rgff_pkg::sqrt_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic v1_reg, v2_reg, v3_reg;

    always_comb begin
        dx_next   = (s_pixel_x >= center_x_reg) ? s_pixel_x - center_x_reg
                                                : center_x_reg - s_pixel_x;
        dy_next   = (s_pixel_y >= center_y_reg) ? s_pixel_y - center_y_reg
                                                : center_y_reg - s_pixel_y;
        sum_next  = SW'(s_chan_a) + SW'(s_chan_b) + SW'(s_chan_c);
        gray_prod = (SW + rgff_pkg::GRAY_MUL_W)'(sum_next) * rgff_pkg::GRAY_MUL;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            dx1_reg       <= dx_next;
            dy1_reg       <= dy_next;
            tag1_reg.ch   <= {s_chan_c, s_chan_b, s_chan_a};
            tag1_reg.sum  <= sum_next;
            tag1_reg.gray <= gray_prod[rgff_pkg::GRAY_SHIFT +: CW];
        end
    end

    // stage 2: squares
    logic [2*CB-1:0] sqx2_reg, sqy2_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            sqx2_reg <= (2*CB)'(dx1_reg) * (2*CB)'(dx1_reg);
            sqy2_reg <= (2*CB)'(dy1_reg) * (2*CB)'(dy1_reg);
            tag2_reg <= tag1_reg;
        end
    end

    // stage 3: scaled squared distance
    logic [rgff_pkg::VAL_W-1:0] val3_reg;
    always_ff @(posedge aclk) begin
        if (advance) begin
            val3_reg <= rgff_pkg::VAL_W'(rgff_pkg::SQ_W'(sqx2_reg) + rgff_pkg::SQ_W'(sqy2_reg))
                        << (2 * rgff_pkg::FRAC_BITS);
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    logic                        sq_valid;
    logic [rgff_pkg::ROOT_W-1:0] sq_root;
    rgff_pkg::sqrt_tag_t         sq_tag;

    assign sq_ctl.advance = advance;
    assign sq_ctl.valid   = v3_reg;

    rgff_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (sq_ctl),
        .in_val    (val3_reg),
        .in_tag    (tag3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // stage 4: zone, offset into the band, band width
    rgff_pkg::zone_t             zone_next;
    logic [rgff_pkg::ROOT_W-1:0] d_full;
    logic [RW-1:0]               w_next;
    logic                        v4_reg, v5_reg, v6_reg;
    rgff_pkg::zone_t             zone4_reg, zone5_reg;
    logic [RW-1:0]               d4_reg, w4_reg;
    logic [rgff_pkg::W3_W-1:0]   w3_4_reg, w3_5_reg, w3_6_reg;
    rgff_pkg::sqrt_tag_t         tag4_reg, tag5_reg;
    rgff_pkg::div_tag_t          tag6_reg;

    always_comb begin
        d_full = sq_root - rgff_pkg::ROOT_W'(inner_reg);
        w_next = outer_reg - inner_reg;
        if (sq_root <= rgff_pkg::ROOT_W'(inner_reg)) begin
            zone_next = rgff_pkg::ZONE_INSIDE;
        end else if (outer_reg <= inner_reg) begin
            zone_next = rgff_pkg::ZONE_GRAY;
        end else if (d_full >= rgff_pkg::ROOT_W'(w_next)) begin
            zone_next = rgff_pkg::ZONE_GRAY;
        end else begin
            zone_next = rgff_pkg::ZONE_FADE;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            zone4_reg <= zone_next;
            d4_reg    <= d_full[RW-1:0];
            w4_reg    <= w_next;
            w3_4_reg  <= rgff_pkg::W3_W'(w_next) + (rgff_pkg::W3_W'(w_next) << 1);
            tag4_reg  <= sq_tag;
        end
    end

    // stage 5: products per channel
    logic [L-1:0][rgff_pkg::PROD_W-1:0]        p1_5_reg;
    logic signed [L-1:0][rgff_pkg::PROD_W-1:0] p2_5_reg;
    logic [L-1:0][SW-1:0]                      c3_next;
    logic signed [L-1:0][SW:0]                 diff_next;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            c3_next[k]   = SW'(tag4_reg.ch[k]) + (SW'(tag4_reg.ch[k]) << 1);
            diff_next[k] = $signed({1'b0, c3_next[k]}) - $signed({1'b0, tag4_reg.sum});
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < L; k++) begin
                p1_5_reg[k] <= rgff_pkg::PROD_W'(c3_next[k]) * rgff_pkg::PROD_W'(w4_reg);
                p2_5_reg[k] <= rgff_pkg::PROD_W'($signed(diff_next[k]))
                               * rgff_pkg::PROD_W'($signed({1'b0, d4_reg}));
            end
            zone5_reg <= zone4_reg;
            w3_5_reg  <= w3_4_reg;
            tag5_reg  <= tag4_reg;
        end
    end

    // stage 6: numerators
    rgff_pkg::num_arr_t num6_reg;
    logic signed [rgff_pkg::PROD_W-1:0] num_diff [L];

    always_comb begin
        for (int k = 0; k < L; k++) begin
            num_diff[k] = $signed(p1_5_reg[k]) - p2_5_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < L; k++) begin
                num6_reg[k] <= num_diff[k][rgff_pkg::NUM_W-1:0];
            end
            w3_6_reg      <= w3_5_reg;
            tag6_reg.zone <= zone5_reg;
            tag6_reg.ch   <= tag5_reg.ch;
            tag6_reg.gray <= tag5_reg.gray;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (advance) begin
            v4_reg <= sq_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    logic                dv_valid;
    rgff_pkg::chan_arr_t dv_quot;
    rgff_pkg::div_tag_t  dv_tag;

    assign dv_ctl.advance = advance;
    assign dv_ctl.valid   = v6_reg;

    rgff_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (dv_ctl),
        .in_num    (num6_reg),
        .in_den    (w3_6_reg),
        .in_tag    (tag6_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_tag   (dv_tag)
    );

    // output register
    rgff_pkg::chan_arr_t out_next;
    rgff_pkg::chan_arr_t out_reg;
    logic [1:0]          zone_reg;

    always_comb begin
        case (dv_tag.zone)
            rgff_pkg::ZONE_INSIDE: out_next = dv_tag.ch;
            rgff_pkg::ZONE_FADE:   out_next = dv_quot;
            rgff_pkg::ZONE_GRAY:   out_next = {L{dv_tag.gray}};
            default:               out_next = dv_tag.ch;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg  <= out_next;
            zone_reg <= dv_tag.zone;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_a = out_reg[0];
    assign m_out_b = out_reg[1];
    assign m_out_c = out_reg[2];
    assign m_zone  = zone_reg;

`include "radial_gray_fade_filter_core_macros.svh"

    `RGFF_ASSERT_NOW(a_gray_equal, m_valid && (m_zone == rgff_pkg::ZONE_GRAY),
        (m_out_a == m_out_b) && (m_out_b == m_out_c))
    `RGFF_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)
    `RGFF_ASSERT_NEXT(a_stall_freezes_pipe, m_valid && !m_ready,
        $stable(dv_valid) && $stable(v6_reg))
    `RGFF_ASSERT_NOW(a_fade_needs_band, v4_reg && (zone4_reg == rgff_pkg::ZONE_FADE),
        (w4_reg != '0) && (d4_reg < w4_reg))

endmodule
